// ===== rtl/core/fupcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Free/use pair coverage map package
// Shared widths, default sizes and the request function codes.
// ----------------------------------------------------------------------------
`default_nettype none

package fupcm_pkg;

   localparam int LOC_W = 16;
   localparam int CNT_W = 8;
   localparam int INC_W = 3;
   localparam int FUNC_W = 2;

   localparam int MAP_ENTRIES_DEF = 65536;
   localparam int RING_DEPTH_DEF = 5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_VISIT = 2'd0,
      FUNC_FREE  = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

endpackage

`default_nettype wire

// ===== rtl/core/fupcm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module fupcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/free_use_pair_coverage_map_unit.sv =====
// ----------------------------------------------------------------------------
// Free/use pair coverage map
// Counts how often a block visit follows a recent free event, keyed by
// visit location XOR (free location >> 1) in a map of 8-bit wrapping counters.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one request per transfer: a block visit, a free
//   event or a read of one map counter. Every request gives exactly one
//   transfer on the rsp_ channel, in order.
//   After reset the block sweeps the counter map to zero, one entry a cycle;
//   req_stall stays high meanwhile.
//   The block works on one request at a time. A free event, a repeated visit
//   or an unused code goes straight to its response. A counter read goes
//   through the map pipeline. For a new visit the free ring is scanned one
//   entry a cycle and each nonempty entry starts a read-modify-write of the
//   map through a three-stage pipeline (index reduction, memory read,
//   increment and write back).
//   The response sits in an output register, so a stalled rsp_ side does not
//   keep the block from taking the next request; only the completion of that
//   next request waits until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module free_use_pair_coverage_map_unit
   import fupcm_pkg::*;
#(
   parameter int MAP_ENTRIES = MAP_ENTRIES_DEF,
   parameter int RING_DEPTH  = RING_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [LOC_W-1:0]  req_location,
   input  wire logic [LOC_W-1:0]  req_read_index,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [CNT_W-1:0]  rsp_counter_value,
   output logic      [INC_W-1:0]  rsp_increments,
   output logic                   rsp_duplicate
);

   localparam int MAP_AW = $clog2(MAP_ENTRIES);
   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
   localparam logic [MAP_AW-1:0] CLR_LAST = MAP_AW'(MAP_ENTRIES - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [MAP_AW-1:0] clr_addr_ff, clr_addr_in;
   logic [LOC_W-1:0] free_ring_ff [RING_DEPTH];
   logic [LOC_W-1:0] free_ring_in [RING_DEPTH];
   logic [LOC_W-1:0] visit_ring_ff [RING_DEPTH];
   logic [LOC_W-1:0] visit_ring_in [RING_DEPTH];
   logic [PTR_W-1:0] free_ptr_ff, free_ptr_in;
   logic [PTR_W-1:0] visit_ptr_ff, visit_ptr_in;
   logic [PTR_W-1:0] scan_ptr_ff, scan_ptr_in;
   logic [LOC_W-1:0] loc_ff, loc_in;
   logic [INC_W-1:0] inc_cnt_ff, inc_cnt_in;
   logic dup_ff, dup_in;
   logic [CNT_W-1:0] value_ff, value_in;

   // Map update pipeline.
   logic s0_valid, s0_rd;
   logic [LOC_W-1:0] s0_val;
   logic s1_valid_ff, s1_rd_ff;
   logic [LOC_W-1:0] s1_val_ff;
   logic [MAP_AW-1:0] s1_idx;
   logic s2_valid_ff, s2_rd_ff;
   logic [MAP_AW-1:0] s2_idx_ff;
   logic last_wr_valid_ff;
   logic [MAP_AW-1:0] last_wr_addr_ff;
   logic [CNT_W-1:0] last_wr_data_ff;

   logic [CNT_W-1:0] ram_rd_data, data_eff, inc_data;
   logic wr_inc, ram_wr_en;
   logic [MAP_AW-1:0] ram_wr_addr;
   logic [CNT_W-1:0] ram_wr_data;

   logic rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] rsp_counter_value_ff;
   logic [INC_W-1:0] rsp_increments_ff;
   logic rsp_duplicate_ff;

   logic accept, out_free;
   logic [LOC_W-1:0] req_shifted;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_shifted = req_location >> 1;

   // Forward the previous cycle's write, which the read-first RAM missed.
   assign data_eff = (last_wr_valid_ff && (last_wr_addr_ff == s2_idx_ff))
                     ? last_wr_data_ff : ram_rd_data;
   assign inc_data = CNT_W'(data_eff + 1'b1);
   assign wr_inc = s2_valid_ff && !s2_rd_ff;

   always_comb begin
      state_in = state_ff;
      clr_addr_in = clr_addr_ff;
      free_ring_in = free_ring_ff;
      visit_ring_in = visit_ring_ff;
      free_ptr_in = free_ptr_ff;
      visit_ptr_in = visit_ptr_ff;
      scan_ptr_in = scan_ptr_ff;
      loc_in = loc_ff;
      inc_cnt_in = inc_cnt_ff;
      dup_in = dup_ff;
      value_in = value_ff;
      s0_valid = 1'b0;
      s0_rd = 1'b0;
      s0_val = req_read_index;

      if (s2_valid_ff && s2_rd_ff) begin
         value_in = data_eff;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = MAP_AW'(clr_addr_ff + 1'b1);
            if (clr_addr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               dup_in = 1'b0;
               inc_cnt_in = '0;
               value_in = '0;
               unique case (func_type'(req_func))
                  FUNC_VISIT: begin
                     if (visit_ring_ff[visit_ptr_ff] == req_shifted) begin
                        dup_in = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        visit_ring_in[visit_ptr_ff] = req_shifted;
                        visit_ptr_in = (visit_ptr_ff == PTR_LAST) ? '0
                                       : PTR_W'(visit_ptr_ff + 1'b1);
                        loc_in = req_location;
                        scan_ptr_in = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_FREE: begin
                     free_ring_in[free_ptr_ff] = req_shifted;
                     free_ptr_in = (free_ptr_ff == PTR_LAST) ? '0
                                   : PTR_W'(free_ptr_ff + 1'b1);
                     state_in = ST_DONE;
                  end
                  FUNC_READ: begin
                     s0_valid = 1'b1;
                     s0_rd = 1'b1;
                     state_in = ST_DRAIN;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            s0_val = free_ring_ff[scan_ptr_ff] ^ loc_ff;
            s0_valid = (free_ring_ff[scan_ptr_ff] != '0);
            if (s0_valid) begin
               inc_cnt_in = INC_W'(inc_cnt_ff + 1'b1);
            end
            if (scan_ptr_ff == PTR_LAST) begin
               state_in = ST_DRAIN;
            end else begin
               scan_ptr_in = PTR_W'(scan_ptr_ff + 1'b1);
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_addr_ff <= '0;
         free_ptr_ff <= '0;
         visit_ptr_ff <= '0;
         scan_ptr_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         last_wr_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            free_ring_ff[i] <= '0;
            visit_ring_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         clr_addr_ff <= clr_addr_in;
         free_ptr_ff <= free_ptr_in;
         visit_ptr_ff <= visit_ptr_in;
         scan_ptr_ff <= scan_ptr_in;
         s1_valid_ff <= s0_valid;
         s2_valid_ff <= s1_valid_ff;
         last_wr_valid_ff <= wr_inc;
         rsp_valid_ff <= rsp_valid_in;
         free_ring_ff <= free_ring_in;
         visit_ring_ff <= visit_ring_in;
      end
   end

   always_ff @(posedge clock) begin
      loc_ff <= loc_in;
      inc_cnt_ff <= inc_cnt_in;
      dup_ff <= dup_in;
      value_ff <= value_in;
      s1_rd_ff <= s0_rd;
      s1_val_ff <= s0_val;
      s2_rd_ff <= s1_rd_ff;
      s2_idx_ff <= s1_idx;
      last_wr_addr_ff <= s2_idx_ff;
      last_wr_data_ff <= inc_data;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_counter_value_ff <= value_ff;
         rsp_increments_ff <= inc_cnt_ff;
         rsp_duplicate_ff <= dup_ff;
      end
   end

   // Index reduction modulo MAP_ENTRIES. The quotient comes from a multiply
   // by a rounded-up reciprocal, which is exact for 16-bit operands, so the
   // remainder needs no correction step.
   generate
      if (MAP_ENTRIES < (1 << LOC_W)) begin : g_reduce
         localparam int SHIFT = LOC_W + MAP_AW;
         localparam int RECIP_W = LOC_W + 2;
         localparam int Q_W = LOC_W - MAP_AW + 1;
         localparam longint unsigned RECIP =
            ((64'd1 << SHIFT) + MAP_ENTRIES - 1) / MAP_ENTRIES;
         localparam logic [RECIP_W-1:0] RECIP_N = RECIP_W'(RECIP);
         localparam logic [LOC_W:0] MAP_N = (LOC_W + 1)'(MAP_ENTRIES);

         logic [LOC_W+RECIP_W-1:0] prod;
         logic [Q_W-1:0] s1_q_ff;
         logic [LOC_W:0] qm, rem;

         assign prod = (LOC_W + RECIP_W)'(s0_val) * (LOC_W + RECIP_W)'(RECIP_N);

         always_ff @(posedge clock) begin
            s1_q_ff <= prod[SHIFT +: Q_W];
         end

         assign qm = (LOC_W + 1)'(s1_q_ff) * MAP_N;
         assign rem = (LOC_W + 1)'(s1_val_ff) - qm;
         assign s1_idx = rem[MAP_AW-1:0];
      end else begin : g_direct
         assign s1_idx = MAP_AW'(s1_val_ff);
      end
   endgenerate

   // The sweep after reset and the increment write share the one write port.
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en = wr_inc;
         ram_wr_addr = s2_idx_ff;
         ram_wr_data = inc_data;
      end
   end

   fupcm_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAP_ENTRIES)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (s1_idx),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_counter_value = rsp_counter_value_ff;
   assign rsp_increments = rsp_increments_ff;
   assign rsp_duplicate = rsp_duplicate_ff;

endmodule

`default_nettype wire

// ===== rtl/core/fupcm_checker.sv =====
// ----------------------------------------------------------------------------
// Free/use pair coverage map checker
// Port-level properties of the coverage map, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fupcm_checker
   import fupcm_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic [FUNC_W-1:0] req_func,
   input wire logic [LOC_W-1:0]  req_location,
   input wire logic [LOC_W-1:0]  req_read_index,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [CNT_W-1:0]  rsp_counter_value,
   input wire logic [INC_W-1:0]  rsp_increments,
   input wire logic              rsp_duplicate
);

   // The map sweep always follows reset, so no request is taken right after.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("request taken during the map sweep");

   // A stalled request holds its payload until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_func)
         && $stable(req_location) && $stable(req_read_index))
      else $error("stalled request changed");

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_counter_value)
         && $stable(rsp_increments) && $stable(rsp_duplicate))
      else $error("stalled response changed");

   // A repeated visit touches no counter and reads none.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_duplicate |-> (rsp_increments == '0)
         && (rsp_counter_value == '0))
      else $error("duplicate visit with counter activity");

   // Only a read returns a counter value, and a read increments nothing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_counter_value != '0) |-> (rsp_increments == '0)
         && !rsp_duplicate)
      else $error("counter value on a non-read response");

endmodule

bind free_use_pair_coverage_map_unit fupcm_checker u_fupcm_checker (.*);

`default_nettype wire
